>>> sv/ffra_pkg.sv
// Shared widths, codes and controller/datapath interface types of the run allocator.
`timescale 1ns / 1ps
`default_nettype none

package ffra_pkg;

  localparam int unsigned START_W        = 10;
  localparam int unsigned LEN_W          = 7;
  localparam int unsigned STATUS_W       = 2;
  localparam int unsigned FREE_W         = 11;
  localparam int unsigned POOL_SLOTS_DEF = 1024;
  localparam int unsigned MAX_RUN_DEF    = 64;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK           = 2'd0,
    ST_NO_SPACE     = 2'd1,
    ST_OUT_OF_RANGE = 2'd2
  } status_e;

  typedef struct packed {
    logic    load;
    logic    scan;
    logic    rel;
    logic    mark;
    logic    clear;
    logic    res_set;
    status_e res_code;
    logic    out_load;
  } cmd_t;

  typedef struct packed {
    logic is_release;
    logic bad_alloc;
    logic bad_release;
    logic hit;
    logic scan_end;
    logic rel_done;
    logic mark_last;
    logic clear_last;
    logic out_busy;
  } stat_t;

endpackage

`default_nettype wire

>>> sv/first_fit_run_allocator.sv
// Top level of the first-fit run allocator: controller plus datapath.
//
//  channel | direction | handshake              | payload
//  in      | input     | in_valid_i/in_ready_o   | action_i, start_slot_i, run_length_i
//  out     | output    | out_valid_o/out_ready_i | status_o, granted_start_o, free_count_o
//
// One request at a time. Allocate: a one-slot-per-cycle scan of the slot map memory,
// then the marking of the run. Release: each slot of the run is read and cleared;
// rejected requests go from the range check straight to the result.
// After reset a clearing pass over all POOL_SLOTS slots runs with in_ready_o low.
// A result waiting in the output register does not block the next request; a request
// that finishes while the output is still stalled holds until it drains.
`timescale 1ns / 1ps
`default_nettype none

module first_fit_run_allocator #(
  parameter int unsigned POOL_SLOTS = ffra_pkg::POOL_SLOTS_DEF,
  parameter int unsigned MAX_RUN    = ffra_pkg::MAX_RUN_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output      logic                          in_ready_o,
  input  wire logic                          action_i,
  input  wire logic [ffra_pkg::START_W-1:0]  start_slot_i,
  input  wire logic [ffra_pkg::LEN_W-1:0]    run_length_i,
  output      logic                          out_valid_o,
  input  wire logic                          out_ready_i,
  output      logic [ffra_pkg::STATUS_W-1:0] status_o,
  output      logic [ffra_pkg::START_W-1:0]  granted_start_o,
  output      logic [ffra_pkg::FREE_W-1:0]   free_count_o
);

  ffra_pkg::cmd_t  cmd;
  ffra_pkg::stat_t stat;

  ffra_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  ffra_dpath #(
    .POOL_SLOTS (POOL_SLOTS),
    .MAX_RUN    (MAX_RUN)
  ) u_dpath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .action_i        (action_i),
    .start_slot_i    (start_slot_i),
    .run_length_i    (run_length_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .status_o        (status_o),
    .granted_start_o (granted_start_o),
    .free_count_o    (free_count_o)
  );

endmodule

`default_nettype wire

>>> sv/ffra_dpath.sv
// Datapath of the run allocator: slot map memory, scan/mark/release pointers, result registers.
`timescale 1ns / 1ps
`default_nettype none

module ffra_dpath #(
  parameter int unsigned POOL_SLOTS = ffra_pkg::POOL_SLOTS_DEF,
  parameter int unsigned MAX_RUN    = ffra_pkg::MAX_RUN_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire ffra_pkg::cmd_t                cmd_i,
  output      ffra_pkg::stat_t               stat_o,
  input  wire logic                          action_i,
  input  wire logic [ffra_pkg::START_W-1:0]  start_slot_i,
  input  wire logic [ffra_pkg::LEN_W-1:0]    run_length_i,
  output      logic                          out_valid_o,
  input  wire logic                          out_ready_i,
  output      logic [ffra_pkg::STATUS_W-1:0] status_o,
  output      logic [ffra_pkg::START_W-1:0]  granted_start_o,
  output      logic [ffra_pkg::FREE_W-1:0]   free_count_o
);

  localparam int unsigned IDX_W = (POOL_SLOTS > 1) ? $clog2(POOL_SLOTS) : 1;
  localparam int unsigned PTR_W = IDX_W + 1;
  localparam int unsigned CNT_W = $clog2(POOL_SLOTS + 1);
  localparam int unsigned LEN_W = ffra_pkg::LEN_W;

  logic                   slot_used_q [POOL_SLOTS];
  logic                   rdata_q;
  logic                   rvalid_q;
  logic [IDX_W-1:0]       tag_q;

  logic                   action_q;
  logic [ffra_pkg::START_W-1:0] start_q;
  logic [LEN_W-1:0]       len_q;

  logic [PTR_W-1:0]       rd_ptr_q, rd_ptr_d;
  logic [IDX_W-1:0]       wr_ptr_q, wr_ptr_d;
  logic [LEN_W-1:0]       cnt_q, cnt_d;
  logic [LEN_W-1:0]       run_q, run_d;
  logic [CNT_W-1:0]       free_q, free_d;

  ffra_pkg::status_e      res_status_q;
  logic [IDX_W-1:0]       res_start_q, res_start_d;

  logic                   out_valid_q;
  ffra_pkg::status_e      out_status_q;
  logic [IDX_W-1:0]       out_start_q;
  logic [CNT_W-1:0]       out_free_q;

  logic                   mem_re, mem_we, mem_wdata;
  logic [IDX_W-1:0]       mem_raddr, mem_waddr;
  logic [LEN_W-1:0]       run_inc;
  logic                   hit;
  logic [PTR_W-1:0]       first_w;

  assign run_inc = run_q + LEN_W'(1);
  assign hit     = rvalid_q && !rdata_q && (run_inc == len_q);
  assign first_w = {1'b0, tag_q} + PTR_W'(1) - PTR_W'(len_q);

  always_comb begin
    stat_o             = '0;
    stat_o.is_release  = action_q;
    stat_o.bad_alloc   = (len_q == '0) || (32'(len_q) > 32'(MAX_RUN)) ||
                         (32'(len_q) > 32'(POOL_SLOTS));
    stat_o.bad_release = (len_q == '0) || (32'(len_q) > 32'(MAX_RUN)) ||
                         ((32'(start_q) + 32'(len_q)) > 32'(POOL_SLOTS));
    stat_o.hit         = hit;
    stat_o.scan_end    = rvalid_q && (tag_q == IDX_W'(POOL_SLOTS - 1));
    stat_o.rel_done    = rvalid_q && (cnt_q == '0);
    stat_o.mark_last   = (cnt_q == LEN_W'(1));
    stat_o.clear_last  = (wr_ptr_q == IDX_W'(POOL_SLOTS - 1));
    stat_o.out_busy    = out_valid_q && !out_ready_i;
  end

  always_comb begin
    mem_re    = 1'b0;
    mem_raddr = rd_ptr_q[IDX_W-1:0];
    mem_we    = 1'b0;
    mem_waddr = wr_ptr_q;
    mem_wdata = 1'b0;
    rd_ptr_d  = rd_ptr_q;
    wr_ptr_d  = wr_ptr_q;
    cnt_d     = cnt_q;
    run_d     = run_q;
    free_d    = free_q;
    res_start_d = res_start_q;

    if (cmd_i.load) begin
      rd_ptr_d    = action_i ? PTR_W'(start_slot_i) : '0;
      cnt_d       = run_length_i;
      run_d       = '0;
      res_start_d = '0;
    end

    if (cmd_i.clear) begin
      mem_we   = 1'b1;
      wr_ptr_d = wr_ptr_q + IDX_W'(1);
    end

    if (cmd_i.scan) begin
      if (rd_ptr_q < PTR_W'(POOL_SLOTS)) begin
        mem_re   = 1'b1;
        rd_ptr_d = rd_ptr_q + PTR_W'(1);
      end
      if (rvalid_q) begin
        run_d = rdata_q ? '0 : run_inc;
      end
      if (hit) begin
        wr_ptr_d    = first_w[IDX_W-1:0];
        cnt_d       = len_q;
        res_start_d = first_w[IDX_W-1:0];
        free_d      = free_q - CNT_W'(len_q);
      end
    end

    if (cmd_i.mark) begin
      mem_we    = 1'b1;
      mem_wdata = 1'b1;
      wr_ptr_d  = wr_ptr_q + IDX_W'(1);
      cnt_d     = cnt_q - LEN_W'(1);
    end

    if (cmd_i.rel) begin
      if (cnt_q != '0) begin
        mem_re   = 1'b1;
        rd_ptr_d = rd_ptr_q + PTR_W'(1);
        cnt_d    = cnt_q - LEN_W'(1);
      end
      if (rvalid_q) begin
        mem_we    = 1'b1;
        mem_waddr = tag_q;
        if (rdata_q) begin
          free_d = free_q + CNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      slot_used_q[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= slot_used_q[mem_raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rvalid_q     <= 1'b0;
      wr_ptr_q     <= '0;
      free_q       <= CNT_W'(POOL_SLOTS);
      out_valid_q  <= 1'b0;
      rd_ptr_q     <= '0;
      cnt_q        <= '0;
      run_q        <= '0;
      res_status_q <= ffra_pkg::ST_OK;
    end else begin
      rvalid_q <= mem_re && !cmd_i.load;
      wr_ptr_q <= wr_ptr_d;
      free_q   <= free_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
      run_q    <= run_d;
      if (cmd_i.res_set) begin
        res_status_q <= cmd_i.res_code;
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    tag_q       <= mem_raddr;
    res_start_q <= res_start_d;
    if (cmd_i.load) begin
      action_q <= action_i;
      start_q  <= start_slot_i;
      len_q    <= run_length_i;
    end
    if (cmd_i.out_load) begin
      out_status_q <= res_status_q;
      out_start_q  <= res_start_q;
      out_free_q   <= free_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = out_status_q;
  assign granted_start_o = ffra_pkg::START_W'(out_start_q);
  assign free_count_o    = ffra_pkg::FREE_W'(out_free_q);

endmodule

`default_nettype wire

>>> sv/ffra_ctrl.sv
// Controller state machine of the run allocator.
`timescale 1ns / 1ps
`default_nettype none

module ffra_ctrl (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output      logic            in_ready_o,
  input  wire ffra_pkg::stat_t stat_i,
  output      ffra_pkg::cmd_t  cmd_o
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_CHECK,
    S_SCAN,
    S_MARK,
    S_REL,
    S_HOLD
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_CLEAR: begin
        cmd_o.clear = 1'b1;
        if (stat_i.clear_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_CHECK;
        end
      end
      S_CHECK: begin
        if (stat_i.is_release) begin
          if (stat_i.bad_release) begin
            cmd_o.res_set  = 1'b1;
            cmd_o.res_code = ffra_pkg::ST_OUT_OF_RANGE;
            state_d        = S_HOLD;
          end else begin
            state_d = S_REL;
          end
        end else if (stat_i.bad_alloc) begin
          cmd_o.res_set  = 1'b1;
          cmd_o.res_code = ffra_pkg::ST_NO_SPACE;
          state_d        = S_HOLD;
        end else begin
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd_o.scan = 1'b1;
        if (stat_i.hit) begin
          cmd_o.res_set  = 1'b1;
          cmd_o.res_code = ffra_pkg::ST_OK;
          state_d        = S_MARK;
        end else if (stat_i.scan_end) begin
          cmd_o.res_set  = 1'b1;
          cmd_o.res_code = ffra_pkg::ST_NO_SPACE;
          state_d        = S_HOLD;
        end
      end
      S_MARK: begin
        cmd_o.mark = 1'b1;
        if (stat_i.mark_last) state_d = S_HOLD;
      end
      S_REL: begin
        cmd_o.rel = 1'b1;
        if (stat_i.rel_done) begin
          cmd_o.res_set  = 1'b1;
          cmd_o.res_code = ffra_pkg::ST_OK;
          state_d        = S_HOLD;
        end
      end
      S_HOLD: begin
        if (!stat_i.out_busy) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o = (state_q == S_IDLE);

endmodule

`default_nettype wire

>>> sv/ffra_checker.sv
// Port-level checker of the run allocator and its bind to the top level.
`timescale 1ns / 1ps
`default_nettype none

module ffra_checker (
  input wire logic                          clk_i,
  input wire logic                          rst_ni,
  input wire logic                          in_valid_i,
  input wire logic                          in_ready_o,
  input wire logic                          out_valid_o,
  input wire logic                          out_ready_i,
  input wire logic [ffra_pkg::STATUS_W-1:0] status_o,
  input wire logic [ffra_pkg::START_W-1:0]  granted_start_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result beat dropped while stalled");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (status_o == ffra_pkg::ST_OK || status_o == ffra_pkg::ST_NO_SPACE ||
                     status_o == ffra_pkg::ST_OUT_OF_RANGE))
    else $error("undefined status code");

  a_fail_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != ffra_pkg::ST_OK |-> granted_start_o == '0)
    else $error("nonzero start on failed request");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("second request taken while one is in progress");

endmodule

bind first_fit_run_allocator ffra_checker u_ffra_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_valid_i),
  .in_ready_o      (in_ready_o),
  .out_valid_o     (out_valid_o),
  .out_ready_i     (out_ready_i),
  .status_o        (status_o),
  .granted_start_o (granted_start_o)
);

`default_nettype wire
